### hdl/bsr_pkg.sv
// Shared types, sizes and codes for the banker's-algorithm allocator.
// No dependencies; used by every module in hdl/.
`timescale 1ns / 1ps
`default_nettype none
package bsr_pkg;
    localparam int NumProcesses = 8;
    localparam int NumResources = 3;
    localparam int UnitBits     = 8;
    localparam int PidxW        = $clog2(NumProcesses);
    // working vector: free units plus every held row, never overflows
    localparam int WorkW        = UnitBits + $clog2(NumProcesses + 1);

    typedef logic [UnitBits-1:0] t_unit;
    typedef logic [WorkW-1:0]    t_work;
    typedef logic [PidxW-1:0]    t_pidx;

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_LOAD = 2'd1,
        OP_REQ  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        STS_SETUP    = 3'd0,
        STS_GRANTED  = 3'd1,
        STS_EXCEEDS  = 3'd2,
        STS_UNSAFE   = 3'd3,
        STS_LOAD_BAD = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SAFE,
        S_RESP
    } t_state;

    typedef struct packed {
        logic  found;
        logic  all_done;
        t_pidx idx;
    } t_pick;
endpackage
`default_nettype wire

### hdl/bankers_safe_request.sv
// Top level of the banker's-algorithm allocator: tables, sequencer, lanes.
// Depends on bsr_pkg, bsr_lane, bsr_merge.
//
// channel  dir  fields (low bit up)
// s_axis   in   tuser: op[1:0]; tdata: process_index, amount_0..2, held_0..2
// m_axis   out  tdata: status[2:0], echo_process[5:3]
//
// Set, load, unused op and refused requests pass from the transfer through EXEC
// and RESP to result valid; a request that passes the bounds check also runs the
// safety check in SAFE (one process retired per cycle by the lane array) before
// RESP. Synchronous active-low reset clears all tables. One item in flight; a new
// transfer is taken once the result is in the output register.
`timescale 1ns / 1ps
`default_nettype none
module bankers_safe_request (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [55:0] s_axis_tdata,   // process_index, amount_0..2, held_0..2, pad
    input  wire [1:0]  s_axis_tuser,   // op
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata    // status, echo_process, pad
);
    localparam int P = bsr_pkg::NumProcesses;
    localparam int R = bsr_pkg::NumResources;

    bsr_pkg::t_state  r_state, n_state;
    bsr_pkg::t_unit   r_free [R];
    bsr_pkg::t_unit   r_held [P][R];
    bsr_pkg::t_unit   r_need [P][R];
    bsr_pkg::t_work   r_work [R];
    logic [P-1:0]     r_done;
    bsr_pkg::t_op     r_op;
    logic [2:0]       r_proc;
    bsr_pkg::t_unit   r_amt [R];
    bsr_pkg::t_unit   r_hld [R];
    bsr_pkg::t_status r_status;
    logic             r_out_valid;
    bsr_pkg::t_status r_out_status;
    logic [2:0]       r_out_proc;

    bsr_pkg::t_unit in_amt [3];
    bsr_pkg::t_unit in_hld [3];
    logic           accept, proc_ok, load_ok, req_ok, slot_free;
    bsr_pkg::t_pidx pi;
    logic [P-1:0]   fits;
    bsr_pkg::t_pick pick;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign slot_free = !r_out_valid || m_axis_tready;
    assign pi        = bsr_pkg::PidxW'(r_proc);
    assign proc_ok   = 32'(r_proc) < P;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            in_amt[k] = bsr_pkg::UnitBits'(s_axis_tdata[3 + 8*k +: 8]);
            in_hld[k] = bsr_pkg::UnitBits'(s_axis_tdata[27 + 8*k +: 8]);
        end
    end

    always_comb begin
        load_ok = proc_ok;
        req_ok  = proc_ok;
        for (int r = 0; r < R; r++) begin
            if (r_hld[r] > r_amt[r]) load_ok = 1'b0;
            if (r_amt[r] > r_need[pi][r] || r_amt[r] > r_free[r]) req_ok = 1'b0;
        end
    end

    for (genvar p = 0; p < P; p++) begin : g_lane
        bsr_lane u_lane (
            .i_need (r_need[p]),
            .i_work (r_work),
            .i_done (r_done[p]),
            .o_fits (fits[p])
        );
    end

    bsr_merge u_merge (
        .i_fits (fits),
        .i_done (r_done),
        .o_pick (pick)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bsr_pkg::S_IDLE: if (accept) n_state = bsr_pkg::S_EXEC;
            bsr_pkg::S_EXEC: begin
                if (r_op == bsr_pkg::OP_REQ && req_ok) n_state = bsr_pkg::S_SAFE;
                else n_state = bsr_pkg::S_RESP;
            end
            bsr_pkg::S_SAFE: if (pick.all_done || !pick.found) n_state = bsr_pkg::S_RESP;
            bsr_pkg::S_RESP: if (slot_free) n_state = bsr_pkg::S_IDLE;
            default: n_state = bsr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == bsr_pkg::S_IDLE);
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_proc, r_out_status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsr_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_done      <= '0;
            for (int r = 0; r < R; r++) begin
                r_free[r] <= '0;
                for (int p = 0; p < P; p++) begin
                    r_held[p][r] <= '0;
                    r_need[p][r] <= '0;
                end
            end
        end else begin
            r_state <= n_state;
            if (r_state == bsr_pkg::S_RESP && slot_free) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
            unique case (r_state)
                bsr_pkg::S_IDLE: begin
                    if (accept) begin
                        r_op   <= bsr_pkg::t_op'(s_axis_tuser);
                        r_proc <= s_axis_tdata[2:0];
                        for (int r = 0; r < R; r++) begin
                            r_amt[r] <= in_amt[r];
                            r_hld[r] <= in_hld[r];
                        end
                    end
                end
                bsr_pkg::S_EXEC: begin
                    case (r_op)
                        bsr_pkg::OP_SET: begin
                            r_status <= bsr_pkg::STS_SETUP;
                            for (int r = 0; r < R; r++) r_free[r] <= r_amt[r];
                        end
                        bsr_pkg::OP_LOAD: begin
                            if (load_ok) begin
                                r_status <= bsr_pkg::STS_SETUP;
                                for (int r = 0; r < R; r++) begin
                                    r_held[pi][r] <= r_hld[r];
                                    r_need[pi][r] <= r_amt[r] - r_hld[r];
                                end
                            end else r_status <= bsr_pkg::STS_LOAD_BAD;
                        end
                        bsr_pkg::OP_REQ: begin
                            if (req_ok) begin
                                // tentative grant, working vector starts at new free
                                r_done <= '0;
                                for (int r = 0; r < R; r++) begin
                                    r_free[r]     <= r_free[r] - r_amt[r];
                                    r_held[pi][r] <= r_held[pi][r] + r_amt[r];
                                    r_need[pi][r] <= r_need[pi][r] - r_amt[r];
                                    r_work[r]     <= bsr_pkg::WorkW'(r_free[r] - r_amt[r]);
                                end
                            end else r_status <= bsr_pkg::STS_EXCEEDS;
                        end
                        default: r_status <= bsr_pkg::STS_SETUP;
                    endcase
                end
                bsr_pkg::S_SAFE: begin
                    if (pick.all_done) begin
                        r_status <= bsr_pkg::STS_GRANTED;
                    end else if (!pick.found) begin
                        r_status <= bsr_pkg::STS_UNSAFE;
                        for (int r = 0; r < R; r++) begin
                            r_free[r]     <= r_free[r] + r_amt[r];
                            r_held[pi][r] <= r_held[pi][r] - r_amt[r];
                            r_need[pi][r] <= r_need[pi][r] + r_amt[r];
                        end
                    end else begin
                        r_done[pick.idx] <= 1'b1;
                        for (int r = 0; r < R; r++)
                            r_work[r] <= r_work[r] + bsr_pkg::WorkW'(r_held[pick.idx][r]);
                    end
                end
                bsr_pkg::S_RESP: begin
                    if (slot_free) begin
                        r_out_status <= r_status;
                        r_out_proc   <= r_proc;
                    end
                end
                default: ;
            endcase
        end
    end

    a_no_take_in_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bsr_pkg::S_SAFE |-> !s_axis_tready)
        else $error("input taken during safety check");

    a_done_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bsr_pkg::S_SAFE && $past(r_state) == bsr_pkg::S_SAFE)
        |-> ((r_done & $past(r_done)) == $past(r_done)))
        else $error("retired process came back");

    a_result_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == bsr_pkg::S_RESP)
        else $error("result raised outside response state");
endmodule
`default_nettype wire

### hdl/bsr_lane.sv
// One process lane of the safety check: does its need fit the working vector.
// Depends on bsr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bsr_lane (
    input  var bsr_pkg::t_unit i_need [bsr_pkg::NumResources],
    input  var bsr_pkg::t_work i_work [bsr_pkg::NumResources],
    input  wire                i_done,
    output logic               o_fits
);
    always_comb begin
        o_fits = !i_done;
        for (int r = 0; r < bsr_pkg::NumResources; r++) begin
            if (bsr_pkg::WorkW'(i_need[r]) > i_work[r]) o_fits = 1'b0;
        end
    end
endmodule
`default_nettype wire

### hdl/bsr_merge.sv
// Merges lane results: lowest fitting process, and whether all have retired.
// Depends on bsr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bsr_merge (
    input  wire  [bsr_pkg::NumProcesses-1:0] i_fits,
    input  wire  [bsr_pkg::NumProcesses-1:0] i_done,
    output bsr_pkg::t_pick                   o_pick
);
    always_comb begin
        o_pick.found    = 1'b0;
        o_pick.idx      = '0;
        o_pick.all_done = &i_done;
        for (int p = bsr_pkg::NumProcesses - 1; p >= 0; p--) begin
            if (i_fits[p]) begin
                o_pick.found = 1'b1;
                o_pick.idx   = bsr_pkg::PidxW'(p);
            end
        end
    end
endmodule
`default_nettype wire
